### rtl/core/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and constants for the register pressure analyzer.
// ----------------------------------------------------------------------------
package rpa_pkg;

   localparam int NUM_ARCH_REGS_DEF = 32;
   localparam int TIME_BITS_DEF     = 10;

   localparam int TIME_IN_W = 10;   // issue_time field width
   localparam int REG_IDX_W = 5;    // register index field width
   localparam int RES_W     = 5;    // result count field width
   localparam int CFG_W     = 8;    // registers_available width

   localparam logic [CFG_W-1:0] AVAIL_RESET = 8'd32;

   typedef struct packed {
      logic [TIME_IN_W-1:0] issue_time;
      logic [REG_IDX_W-1:0] source_a;
      logic [REG_IDX_W-1:0] source_b;
      logic [REG_IDX_W-1:0] destination;
      logic                 final_item;
   } req_type;

   typedef struct packed {
      logic [RES_W-1:0] peak_pressure;
      logic [RES_W-1:0] mean_pressure;
      logic             spill_flag;
      logic [RES_W-1:0] spill_excess;
      logic [RES_W-1:0] range_count;
   } rsp_type;

endpackage

### rtl/core/rpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/register_pressure_analyzer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_pressure_analyzer
// Collects live ranges of scheduled instructions and reports peak and mean
// register pressure plus spill figures at the end of each block.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one scheduled instruction per transfer. A non-final item passes
//            through accept, source A, source B and destination steps;
//            req_ready is low while an item is being worked on.
//   rsp_*  : one result per item marked final_item, none otherwise.
//   csr_*  : write of registers_available, always ready; write only while idle.
// A final item is followed by a sweep of every time point against every
// register using one shared compare unit, reading the birth and last-use
// RAMs one entry per cycle, then a restoring divider for the mean.
// The result sits in an output register; a new item is accepted while it
// waits, and only the next result waits for rsp_ready.
// Reset (synchronous) clears the defined/used marks, returns the sequencer
// to idle and sets registers_available to 32. Birth and last-use RAMs need
// no clearing since entries are read only behind their marks.
// ----------------------------------------------------------------------------
module register_pressure_analyzer import rpa_pkg::*; #(
   parameter int NUM_ARCH_REGS = NUM_ARCH_REGS_DEF,
   parameter int TIME_BITS     = TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int AW    = $clog2(NUM_ARCH_REGS);
   localparam int TW    = TIME_BITS;
   localparam int CNT_W = $clog2(NUM_ARCH_REGS + 1);
   localparam int PT_W  = TW + 1;
   localparam int TOT_W = TW + CNT_W;
   localparam int DC_W  = $clog2(TOT_W);
   localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SRC_A = 9'b000000010,
      S_SRC_B = 9'b000000100,
      S_DEST  = 9'b000001000,
      S_SWEEP = 9'b000010000,
      S_DRAIN = 9'b000100000,
      S_PREP  = 9'b001000000,
      S_DIV   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [CFG_W-1:0]        avail_ff, avail_in;
   logic [NUM_ARCH_REGS-1:0] defined_ff, defined_in;
   logic [NUM_ARCH_REGS-1:0] used_ff, used_in;

   // sweep issue and evaluate stages
   logic [TW-1:0]    p_ff, p_in;
   logic [AW-1:0]    r_ff, r_in;
   logic             sv_ff, sv_in;
   logic [TW-1:0]    p_d_ff, p_d_in;
   logic [AW-1:0]    r_d_ff, r_d_in;

   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0] ranges_ff, ranges_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [PT_W-1:0]  points_ff, points_in;

   // restoring divider
   logic [TOT_W-1:0] quo_ff, quo_in;
   logic [PT_W-1:0]  rem_ff, rem_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // RAM ports
   logic             b_we, l_we;
   logic [AW-1:0]    b_wa, l_wa;
   logic [TW-1:0]    b_wd, l_wd;
   logic [TW-1:0]    birth_q, last_q;

   logic [TW-1:0]    t_cur;
   logic [AW-1:0]    a_idx, b_idx, d_idx;
   logic             a_ok, b_ok, d_ok;
   logic             last_issue;
   logic             keep_r, hit;
   logic [TW-1:0]    death;
   logic [CNT_W-1:0] live_sum;
   logic             rsp_load;
   logic [PT_W:0]    rem_sh;
   logic [PT_W:0]    rem_diff;
   logic [CMP_W-1:0] peak_ext, avail_ext;

   rpa_ram #(.WIDTH(TW), .DEPTH(NUM_ARCH_REGS)) u_birth_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_wa),
      .wr_data (b_wd),
      .rd_addr (r_ff),
      .rd_data (birth_q)
   );

   rpa_ram #(.WIDTH(TW), .DEPTH(NUM_ARCH_REGS)) u_last_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_wa),
      .wr_data (l_wd),
      .rd_addr (r_ff),
      .rd_data (last_q)
   );

   assign t_cur = TW'(item_ff.issue_time);
   assign a_idx = AW'(item_ff.source_a);
   assign b_idx = AW'(item_ff.source_b);
   assign d_idx = AW'(item_ff.destination);
   assign a_ok  = (item_ff.source_a != '0) && (32'(item_ff.source_a) < NUM_ARCH_REGS);
   assign b_ok  = (item_ff.source_b != '0) && (32'(item_ff.source_b) < NUM_ARCH_REGS);
   assign d_ok  = (item_ff.destination != '0)
                  && (32'(item_ff.destination) < NUM_ARCH_REGS);

   assign last_issue = (r_ff == AW'(NUM_ARCH_REGS - 1)) && (&p_ff);

   // evaluate stage: one register against one time point
   assign death    = used_ff[r_d_ff] ? last_q : birth_q;
   assign keep_r   = defined_ff[r_d_ff] && (!used_ff[r_d_ff] || (last_q >= birth_q));
   assign hit      = keep_r && (birth_q <= p_d_ff) && (p_d_ff <= death);
   assign live_sum = ((r_d_ff == '0) ? '0 : live_ff) + CNT_W'(hit);

   assign rem_sh   = {rem_ff, quo_ff[TOT_W-1]};
   assign rem_diff = rem_sh - {1'b0, points_ff};

   assign peak_ext  = CMP_W'(peak_ff);
   assign avail_ext = CMP_W'(avail_ff);

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // sequencer and store updates
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      defined_in = defined_ff;
      used_in    = used_ff;
      b_we = 1'b0;
      b_wa = '0;
      b_wd = '0;
      l_we = 1'b0;
      l_wa = '0;
      l_wd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_SRC_A;
            end
         end
         S_SRC_A: begin
            if (a_ok) begin
               used_in[a_idx] = 1'b1;
               l_we = 1'b1;
               l_wa = a_idx;
               l_wd = t_cur;
               if (!defined_ff[a_idx]) begin
                  defined_in[a_idx] = 1'b1;
                  b_we = 1'b1;
                  b_wa = a_idx;
               end
            end
            state_in = S_SRC_B;
         end
         S_SRC_B: begin
            if (b_ok) begin
               used_in[b_idx] = 1'b1;
               l_we = 1'b1;
               l_wa = b_idx;
               l_wd = t_cur;
               if (!defined_ff[b_idx]) begin
                  defined_in[b_idx] = 1'b1;
                  b_we = 1'b1;
                  b_wa = b_idx;
               end
            end
            state_in = S_DEST;
         end
         S_DEST: begin
            if (d_ok && !defined_ff[d_idx]) begin
               defined_in[d_idx] = 1'b1;
               b_we = 1'b1;
               b_wa = d_idx;
               b_wd = t_cur;
            end
            state_in = item_ff.final_item ? S_SWEEP : S_IDLE;
         end
         S_SWEEP: begin
            if (last_issue) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            defined_in = '0;
            used_in    = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (dcnt_ff == DC_W'(TOT_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sweep counters, accumulators and divider
   always_comb begin
      p_in      = p_ff;
      r_in      = r_ff;
      sv_in     = (state_ff == S_SWEEP);
      p_d_in    = p_ff;
      r_d_in    = r_ff;
      live_in   = live_ff;
      peak_in   = peak_ff;
      ranges_in = ranges_ff;
      total_in  = total_ff;
      points_in = points_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;

      if (state_ff == S_DEST) begin
         p_in      = '0;
         r_in      = '0;
         live_in   = '0;
         peak_in   = '0;
         ranges_in = '0;
         total_in  = '0;
         points_in = '0;
      end else if (state_ff == S_SWEEP) begin
         if (r_ff == AW'(NUM_ARCH_REGS - 1)) begin
            r_in = '0;
            p_in = p_ff + TW'(1);
         end else begin
            r_in = r_ff + AW'(1);
         end
      end

      if (sv_ff) begin
         if ((p_d_ff == '0) && keep_r) begin
            ranges_in = ranges_ff + CNT_W'(1);
         end
         live_in = live_sum;
         // close out a time point after its last register
         if ((r_d_ff == AW'(NUM_ARCH_REGS - 1)) && (live_sum != '0)) begin
            if (live_sum > peak_ff) begin
               peak_in = live_sum;
            end
            total_in  = total_ff + TOT_W'(live_sum);
            points_in = points_ff + PT_W'(1);
         end
      end

      if (state_ff == S_PREP) begin
         quo_in  = total_ff;
         rem_in  = '0;
         dcnt_in = '0;
      end else if (state_ff == S_DIV) begin
         if (!rem_diff[PT_W]) begin
            rem_in = rem_diff[PT_W-1:0];
            quo_in = {quo_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[PT_W-1:0];
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + DC_W'(1);
      end
   end

   // result register and configuration
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      avail_in     = avail_ff;
      if (csr_valid) begin
         avail_in = csr_data;
      end
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.peak_pressure  = RES_W'(peak_ff);
         rsp_data_in.mean_pressure  = (points_ff == '0) ? '0 : RES_W'(quo_ff);
         rsp_data_in.spill_flag     = peak_ext > avail_ext;
         rsp_data_in.spill_excess   = (peak_ext > avail_ext)
                                      ? RES_W'(peak_ext - avail_ext) : '0;
         rsp_data_in.range_count    = RES_W'(ranges_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         defined_ff   <= '0;
         used_ff      <= '0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         avail_ff     <= AVAIL_RESET;
      end else begin
         state_ff     <= state_in;
         defined_ff   <= defined_in;
         used_ff      <= used_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
         avail_ff     <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      p_ff        <= p_in;
      r_ff        <= r_in;
      p_d_ff      <= p_d_in;
      r_d_ff      <= r_d_in;
      live_ff     <= live_in;
      peak_ff     <= peak_in;
      ranges_ff   <= ranges_in;
      total_ff    <= total_in;
      points_ff   <= points_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/rpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks for the register pressure analyzer, bound to the top.
// ----------------------------------------------------------------------------
module rpa_checker import rpa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   // a pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // excess is only reported alongside the spill flag
   a_excess: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.spill_flag |-> rsp_data.spill_excess == '0)
      else $error("spill excess without spill flag");

   // busy right after any input transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous item in work");

   // a non-final item returns to idle after its source and destination steps
   a_short: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.final_item |-> ##4 req_ready)
      else $error("non-final item did not return to idle");

endmodule

bind register_pressure_analyzer rpa_checker u_rpa_checker (.*);

### tb/tb_register_pressure_analyzer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_pressure_analyzer
// Self-checking bench for the register pressure analyzer. A short table of
// directed instructions comes first. Some of its rows carry a hand-written
// result and the rest go through the predictor. It is followed by random
// instruction blocks of varied shape under changing available-register
// counts. Each block ends with a final item; every report is checked field by
// field against its hand-written result or a behavioral live-range model.
// ----------------------------------------------------------------------------
module tb_register_pressure_analyzer;
   import rpa_pkg::*;

   localparam int          CLK_HALF     = 10;
   localparam int unsigned CYCLE_LIMIT  = 250_000_000;
   localparam int          RAND_ITEMS   = 1600;
   localparam int          RAND_BLOCKS  = 36;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          NREGS        = 1 << REG_IDX_W;
   localparam int          NPOINTS      = 1 << TIME_IN_W;
   localparam int          DIR_ROWS     = 23;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   register_pressure_analyzer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Columns: issue_time, source_a, source_b, destination, final_item,
   // has hand-written result, peak, mean, spill, excess, ranges.
   int dir_plan [0:DIR_ROWS-1][0:10] = '{
      '{   0,  0,  0,  0, 1,  1, 0, 0, 0, 0, 0},   // empty store, nothing live
      '{1023,  0,  0, 31, 1,  1, 1, 1, 0, 0, 1},   // write only, never read
      '{1023, 31,  0,  0, 1,  1, 1, 1, 0, 0, 1},   // read before any write
      '{ 100,  0,  0,  5, 0,  0, 0, 0, 0, 0, 0},
      '{  50,  5,  0,  0, 1,  1, 0, 0, 0, 0, 0},   // last use before birth: dropped
      '{   0,  7,  7,  7, 1,  1, 1, 1, 0, 0, 1},
      '{1023, 31, 31, 31, 1,  1, 1, 1, 0, 0, 1},
      // every register from 1 to 31 live at the last time point
      '{1023,  1,  2,  3, 0,  0, 0, 0, 0, 0, 0},
      '{1023,  4,  5,  6, 0,  0, 0, 0, 0, 0, 0},
      '{1023,  7,  8,  9, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 10, 11, 12, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 13, 14, 15, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 16, 17, 18, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 19, 20, 21, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 22, 23, 24, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 25, 26, 27, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 28, 29, 30, 0,  0, 0, 0, 0, 0, 0},
      '{1023, 31,  0,  0, 1,  0, 0, 0, 0, 0, 0},
      // mixed block: redefinition ignored, read and write in one item
      '{ 682,  0,  3,  0, 0,  0, 0, 0, 0, 0, 0},
      '{ 200,  0,  0,  3, 0,  0, 0, 0, 0, 0, 0},
      '{ 341,  4,  0,  4, 0,  0, 0, 0, 0, 0, 0},
      '{ 700,  0,  0,  9, 0,  0, 0, 0, 0, 0, 0},
      '{   0,  0,  0,  0, 1,  0, 0, 0, 0, 0, 0}
   };

   // Model of the live-range store
   bit                   born_known [NREGS];
   logic [TIME_IN_W-1:0] born_at    [NREGS];
   bit                   read_seen  [NREGS];
   logic [TIME_IN_W-1:0] read_at    [NREGS];
   logic [CFG_W-1:0]     phys_regs = AVAIL_RESET;

   rsp_type     pending_reports [$];
   int          mismatches   = 0;
   int          items_sent   = 0;
   int          results_seen = 0;
   int          spills_seen  = 0;
   int          cfg_writes   = 0;
   int unsigned cycle_count  = 0;
   bit          calm         = 1'b0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic void note_source(input logic [REG_IDX_W-1:0] r,
                                       input logic [TIME_IN_W-1:0] t);
      if (r == 0)
         return;
      read_seen[r] = 1'b1;
      read_at[r]   = t;
      if (!born_known[r]) begin
         born_known[r] = 1'b1;
         born_at[r]    = '0;
      end
   endfunction

   function automatic void note_dest(input logic [REG_IDX_W-1:0] r,
                                     input logic [TIME_IN_W-1:0] t);
      if (r == 0 || born_known[r])
         return;
      born_known[r] = 1'b1;
      born_at[r]    = t;
   endfunction

   // Applies one instruction; returns 1 with the pressure report on a final item.
   function automatic bit analyze_instr(input req_type it, output rsp_type rep);
      int                   delta [0:NPOINTS];
      int                   live, peak, total, points, ranges, mean;
      logic [TIME_IN_W-1:0] last;
      rep = '0;
      note_source(it.source_a, it.issue_time);
      note_source(it.source_b, it.issue_time);
      note_dest(it.destination, it.issue_time);
      if (!it.final_item)
         return 1'b0;
      foreach (delta[i])
         delta[i] = 0;
      ranges = 0;
      for (int r = 0; r < NREGS; r++) begin
         if (born_known[r]) begin
            last = read_seen[r] ? read_at[r] : born_at[r];
            if (last >= born_at[r]) begin
               ranges++;
               delta[born_at[r]]++;
               delta[int'(last) + 1]--;
            end
         end
      end
      live   = 0;
      peak   = 0;
      total  = 0;
      points = 0;
      for (int p = 0; p < NPOINTS; p++) begin
         live += delta[p];
         if (live > 0) begin
            if (live > peak)
               peak = live;
            total += live;
            points++;
         end
      end
      mean = (points > 0) ? total / points : 0;
      rep.peak_pressure = RES_W'(peak);
      rep.mean_pressure = RES_W'(mean);
      rep.range_count   = RES_W'(ranges);
      if (peak > phys_regs) begin
         rep.spill_flag   = 1'b1;
         rep.spill_excess = RES_W'(peak - phys_regs);
      end
      for (int r = 0; r < NREGS; r++) begin
         born_known[r] = 1'b0;
         read_seen[r]  = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [REG_IDX_W-1:0] pick_reg(input bit edgy);
      if (edgy) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return REG_IDX_W'(1);
            2:       return REG_IDX_W'(NREGS - 2);
            default: return '1;
         endcase
      end
      if ($urandom_range(0, 99) < 15)
         return '0;
      return REG_IDX_W'($urandom_range(1, NREGS - 1));
   endfunction

   function automatic logic [CFG_W-1:0] avail_for_phase(input int k);
      case (k)
         0:       return '0;
         1:       return '1;
         2:       return CFG_W'(1);
         3:       return CFG_W'(31);
         default: begin
            if ($urandom_range(0, 4) == 0)
               return $urandom_range(0, 1) ? '1 : '0;
            return CFG_W'($urandom_range(8, 32));
         end
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_type it, input bit typed, input rsp_type given);
      rsp_type rep;
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (!req_ready);
      if (analyze_instr(it, rep))
         pending_reports.push_back(typed ? given : rep);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_avail(input logic [CFG_W-1:0] value);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      phys_regs = value;
      cfg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Wait for every report, then let the block fall idle.
   task automatic settle();
      req_valid = 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= 7);

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.spill_flag)
            spills_seen++;
         if (pending_reports.size() == 0) begin
            report("pressure report with none outstanding");
         end else begin
            want = pending_reports.pop_front();
            check_field("peak_pressure", int'(rsp_data.peak_pressure),
                        int'(want.peak_pressure));
            check_field("mean_pressure", int'(rsp_data.mean_pressure),
                        int'(want.mean_pressure));
            check_field("spill_flag",    int'(rsp_data.spill_flag),
                        int'(want.spill_flag));
            check_field("spill_excess",  int'(rsp_data.spill_excess),
                        int'(want.spill_excess));
            check_field("range_count",   int'(rsp_data.range_count),
                        int'(want.range_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("register_pressure_analyzer verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      req_type              it;
      rsp_type              given;
      logic [TIME_IN_W-1:0] t, base;
      int                   blk, len, mode, rand_items;
      blk        = 0;
      rand_items = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         it.issue_time         = TIME_IN_W'(dir_plan[i][0]);
         it.source_a           = REG_IDX_W'(dir_plan[i][1]);
         it.source_b           = REG_IDX_W'(dir_plan[i][2]);
         it.destination        = REG_IDX_W'(dir_plan[i][3]);
         it.final_item         = dir_plan[i][4] != 0;
         given.peak_pressure   = RES_W'(dir_plan[i][6]);
         given.mean_pressure   = RES_W'(dir_plan[i][7]);
         given.spill_flag      = dir_plan[i][8] != 0;
         given.spill_excess    = RES_W'(dir_plan[i][9]);
         given.range_count     = RES_W'(dir_plan[i][10]);
         send_item(it, dir_plan[i][5] != 0, given);
      end

      while (rand_items < RAND_ITEMS || blk < RAND_BLOCKS) begin
         if (blk % 3 == 0) begin
            settle();
            write_avail(avail_for_phase(blk / 3));
         end
         calm = (blk >= 6 && blk < 10);
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                            : $urandom_range(1, 60);
         mode = $urandom_range(0, 3);
         t    = TIME_IN_W'($urandom_range(0, NPOINTS - 1));
         base = t;
         for (int n = 0; n < len; n++) begin
            case (mode)
               0:       t = t + TIME_IN_W'($urandom_range(0, 8));   // scheduled order
               1:       t = TIME_IN_W'($urandom_range(0, NPOINTS - 1));
               2:       t = base + TIME_IN_W'($urandom_range(0, 3));
               default: t = $urandom_range(0, 1) ? '1 : '0;
            endcase
            it.issue_time  = t;
            it.source_a    = pick_reg(mode == 3);
            it.source_b    = pick_reg(mode == 3);
            it.destination = pick_reg(mode == 3);
            it.final_item  = (n == len - 1);
            send_item(it, 1'b0, '0);
            rand_items++;
         end
         blk++;
      end
      calm = 1'b0;
      settle();

      $display("Checked %0d pressure reports from %0d instructions, %0d of them spilling.",
               results_seen, items_sent, spills_seen);
      $display("Available-register count was rewritten %0d times.", cfg_writes);
      if (mismatches == 0)
         $display("register_pressure_analyzer verification clean");
      else
         $display("register_pressure_analyzer verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_ram.sv
rtl/core/register_pressure_analyzer.sv
rtl/core/rpa_checker.sv
tb/tb_register_pressure_analyzer.sv
